// ----- src/qmsm_pkg.sv -----
// Shared types and constants for the quad motor spin-up mixer.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package qmsm_pkg;

	localparam int ElapsedW  = 8;
	localparam int CtlW      = 12;
	localparam int MotorW    = 10;
	localparam int StageW    = 14;
	localparam int CntW      = 16;
	localparam int NumMotors = 4;
	// four 12-bit signed terms summed
	localparam int MixW      = CtlW + 2;
	localparam int AddrW     = 4;
	localparam int DataW     = 32;

	localparam logic [MotorW-1:0] IdleReset  = 10'd200;
	localparam logic [MotorW-1:0] MaxReset   = 10'd1000;
	localparam logic [StageW-1:0] StageReset = 14'd300;

	typedef enum logic [1:0] {
		REG_IDLE  = 2'd0,
		REG_MAX   = 2'd1,
		REG_STAGE = 2'd2
	} reg_idx_t;

	typedef logic [MotorW-1:0] motor_t;
	typedef logic signed [CtlW-1:0] ctl_t;

	typedef struct packed {
		logic [MotorW-1:0] idle_level;
		logic [MotorW-1:0] max_level;
		logic [StageW-1:0] stage_ms;
	} cfg_t;

endpackage

`default_nettype wire

// ----- src/qmsm_if.sv -----
// Valid/ready channel interfaces: tick input and motor command output.
// Depends on qmsm_pkg for field widths.
`default_nettype none

interface qmsm_tick_if;
	logic                                valid;
	logic                                ready;
	logic [qmsm_pkg::ElapsedW-1:0]       elapsed_ms;
	logic                                armed;
	logic signed [qmsm_pkg::CtlW-1:0]    throttle;
	logic signed [qmsm_pkg::CtlW-1:0]    yaw_ctl;
	logic signed [qmsm_pkg::CtlW-1:0]    roll_ctl;
	logic signed [qmsm_pkg::CtlW-1:0]    pitch_ctl;

	modport source (
		output valid, elapsed_ms, armed, throttle, yaw_ctl, roll_ctl, pitch_ctl,
		input  ready
	);
	modport sink (
		input  valid, elapsed_ms, armed, throttle, yaw_ctl, roll_ctl, pitch_ctl,
		output ready
	);
endinterface

interface qmsm_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [qmsm_pkg::MotorW-1:0]   motor_front_right;
	logic [qmsm_pkg::MotorW-1:0]   motor_front_left;
	logic [qmsm_pkg::MotorW-1:0]   motor_rear_left;
	logic [qmsm_pkg::MotorW-1:0]   motor_rear_right;
	logic                          spun_up;

	modport source (
		output valid, motor_front_right, motor_front_left, motor_rear_left,
		       motor_rear_right, spun_up,
		input  ready
	);
	modport sink (
		input  valid, motor_front_right, motor_front_left, motor_rear_left,
		       motor_rear_right, spun_up,
		output ready
	);
endinterface

`default_nettype wire

// ----- src/qmsm_regs.sv -----
// APB-style configuration registers: idle level, max level, stage length.
// Depends on qmsm_pkg (cfg_t, register indexes, reset values).
`default_nettype none

module qmsm_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [qmsm_pkg::AddrW-1:0]    paddr,
	input  wire logic [qmsm_pkg::DataW-1:0]    pwdata,
	output logic      [qmsm_pkg::DataW-1:0]    prdata,
	output logic                               pready,
	output qmsm_pkg::cfg_t                     cfg
);

	qmsm_pkg::cfg_t     cfg_q;
	qmsm_pkg::reg_idx_t idx;
	logic               wr_en;

	// low address bits are ignored: registers are word aligned
	assign idx    = qmsm_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.idle_level <= qmsm_pkg::IdleReset;
			cfg_q.max_level  <= qmsm_pkg::MaxReset;
			cfg_q.stage_ms   <= qmsm_pkg::StageReset;
		end else if (wr_en) begin
			unique case (idx)
				qmsm_pkg::REG_IDLE:  cfg_q.idle_level <= pwdata[qmsm_pkg::MotorW-1:0];
				qmsm_pkg::REG_MAX:   cfg_q.max_level  <= pwdata[qmsm_pkg::MotorW-1:0];
				qmsm_pkg::REG_STAGE: cfg_q.stage_ms   <= pwdata[qmsm_pkg::StageW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			qmsm_pkg::REG_IDLE:  prdata = 32'(cfg_q.idle_level);
			qmsm_pkg::REG_MAX:   prdata = 32'(cfg_q.max_level);
			qmsm_pkg::REG_STAGE: prdata = 32'(cfg_q.stage_ms);
			default:             prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ----- src/qmsm_mixer.sv -----
// X-quad mixer: four signed sums of the controls, each clamped to idle..max.
// Depends on qmsm_pkg (cfg_t, widths).
`default_nettype none

module qmsm_mixer (
	input  wire qmsm_pkg::cfg_t                  cfg,
	input  wire logic signed [qmsm_pkg::CtlW-1:0] throttle,
	input  wire logic signed [qmsm_pkg::CtlW-1:0] yaw_ctl,
	input  wire logic signed [qmsm_pkg::CtlW-1:0] roll_ctl,
	input  wire logic signed [qmsm_pkg::CtlW-1:0] pitch_ctl,
	output qmsm_pkg::motor_t                     mix [qmsm_pkg::NumMotors]
);

	localparam int MixW = qmsm_pkg::MixW;

	logic signed [MixW-1:0] thr_x, yaw_x, rol_x, pit_x;
	logic signed [MixW-1:0] sum [qmsm_pkg::NumMotors];
	logic signed [MixW-1:0] idle_x, max_x;

	// when idle exceeds max, sums below idle give idle and all others give max
	function automatic qmsm_pkg::motor_t clamp_cmd(
		input logic signed [MixW-1:0] x,
		input logic signed [MixW-1:0] lo,
		input logic signed [MixW-1:0] hi
	);
		qmsm_pkg::motor_t r;
		if (x < lo)
			r = lo[qmsm_pkg::MotorW-1:0];
		else if (x > hi)
			r = hi[qmsm_pkg::MotorW-1:0];
		else
			r = x[qmsm_pkg::MotorW-1:0];
		return r;
	endfunction

	assign thr_x  = MixW'(throttle);
	assign yaw_x  = MixW'(yaw_ctl);
	assign rol_x  = MixW'(roll_ctl);
	assign pit_x  = MixW'(pitch_ctl);
	assign idle_x = signed'(MixW'(cfg.idle_level));
	assign max_x  = signed'(MixW'(cfg.max_level));

	assign sum[0] = thr_x + yaw_x - rol_x + pit_x;
	assign sum[1] = thr_x - yaw_x + rol_x + pit_x;
	assign sum[2] = thr_x + yaw_x + rol_x - pit_x;
	assign sum[3] = thr_x - yaw_x - rol_x - pit_x;

	always_comb begin
		for (int k = 0; k < qmsm_pkg::NumMotors; k++)
			mix[k] = clamp_cmd(sum[k], idle_x, max_x);
	end

endmodule

`default_nettype wire

// ----- src/quad_motor_spinup_mixer_top.sv -----
// Top level of the quad motor spin-up sequencer and mixer.
// Uses qmsm_pkg, qmsm_tick_if / qmsm_cmd_if, qmsm_regs and qmsm_mixer.
//
// Usage:
//   tick_in  carries one tick (elapsed ms, armed, four controls) per transfer.
//   cmd_out  returns exactly one result per tick: four motor commands and
//            the spun_up flag, in tick order.
//   APB port writes idle_level (0x0), max_level (0x4) and stage_ms (0x8);
//   write only while no tick is in flight.
// Timing: a tick goes into an input register, then the spin-up/mix logic
//   updates the state and the output register, and the result transfers
//   from the output register. One tick per cycle is sustained while cmd_out
//   is ready; the state feedback (counter, ready, motor hold) closes in a
//   single step.
// Stall: while cmd_out is held off, the result stays in the output register
//   and the input register takes one more tick only if it is empty; then
//   tick_in.ready drops.
// Reset: clears both valid bits, the counter, the ready flag and the motor
//   hold values; config returns to 200 / 1000 / 300.
`default_nettype none

module quad_motor_spinup_mixer_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	qmsm_tick_if.sink                          tick_in,
	qmsm_cmd_if.source                         cmd_out,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [qmsm_pkg::AddrW-1:0]    paddr,
	input  wire logic [qmsm_pkg::DataW-1:0]    pwdata,
	output logic      [qmsm_pkg::DataW-1:0]    prdata,
	output logic                               pready
);

	localparam int CntW = qmsm_pkg::CntW;
	localparam int NM   = qmsm_pkg::NumMotors;

	qmsm_pkg::cfg_t cfg;

	// input register
	logic                          valid_s1;
	logic [qmsm_pkg::ElapsedW-1:0] elapsed_s1;
	logic                          armed_s1;
	qmsm_pkg::ctl_t                thr_s1, yaw_s1, rol_s1, pit_s1;

	// state, which also forms the output payload
	logic                          out_valid_q;
	logic [CntW-1:0]               counter_q;
	logic                          ready_q;
	qmsm_pkg::motor_t              hold_q [NM];

	logic                          advance, step, in_xfer;
	logic [CntW-1:0]               cnt_sum, th1, th2, th3, th4;
	logic                          finish;
	logic [CntW-1:0]               counter_n;
	logic                          ready_n;
	qmsm_pkg::motor_t              hold_n [NM];
	qmsm_pkg::motor_t              mix [NM];

	qmsm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	qmsm_mixer u_mixer (
		.cfg       (cfg),
		.throttle  (thr_s1),
		.yaw_ctl   (yaw_s1),
		.roll_ctl  (rol_s1),
		.pitch_ctl (pit_s1),
		.mix       (mix)
	);

	assign advance       = !out_valid_q || cmd_out.ready;
	assign step          = valid_s1 && advance;
	assign tick_in.ready = !valid_s1 || advance;
	assign in_xfer       = tick_in.valid && tick_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (tick_in.ready)
			valid_s1 <= tick_in.valid;
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			elapsed_s1 <= tick_in.elapsed_ms;
			armed_s1   <= tick_in.armed;
			thr_s1     <= tick_in.throttle;
			yaw_s1     <= tick_in.yaw_ctl;
			rol_s1     <= tick_in.roll_ctl;
			pit_s1     <= tick_in.pitch_ctl;
		end
	end

	// stage thresholds; 4*S of a 14-bit S still fits in 16 bits
	assign th1     = CntW'(cfg.stage_ms);
	assign th2     = th1 << 1;
	assign th3     = th2 + th1;
	assign th4     = th1 << 2;
	assign cnt_sum = counter_q + CntW'(elapsed_s1);
	assign finish  = cnt_sum >= th4;

	always_comb begin
		counter_n = counter_q;
		ready_n   = ready_q;
		hold_n    = hold_q;
		if (!armed_s1) begin
			ready_n = 1'b0;
			for (int k = 0; k < NM; k++)
				hold_n[k] = '0;
		end else if (ready_q) begin
			hold_n = mix;
		end else if (finish) begin
			ready_n   = 1'b1;
			counter_n = '0;
			hold_n    = mix;
		end else begin
			counter_n = cnt_sum;
			if (cnt_sum < th1)
				hold_n[0] = cfg.idle_level;
			else if (cnt_sum < th2)
				hold_n[1] = cfg.idle_level;
			else if (cnt_sum < th3)
				hold_n[2] = cfg.idle_level;
			else
				hold_n[3] = cfg.idle_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			counter_q   <= '0;
			ready_q     <= 1'b0;
			for (int k = 0; k < NM; k++)
				hold_q[k] <= '0;
		end else begin
			if (advance)
				out_valid_q <= valid_s1;
			if (step) begin
				counter_q <= counter_n;
				ready_q   <= ready_n;
				hold_q    <= hold_n;
			end
		end
	end

	assign cmd_out.valid             = out_valid_q;
	assign cmd_out.motor_front_right = hold_q[0];
	assign cmd_out.motor_front_left  = hold_q[1];
	assign cmd_out.motor_rear_left   = hold_q[2];
	assign cmd_out.motor_rear_right  = hold_q[3];
	assign cmd_out.spun_up           = ready_q;

`ifndef SYNTHESIS
	// a disarmed tick yields a valid result with all motors off
	a_disarm_zero: assert property (@(posedge clk) disable iff (!arst_n)
		step && !armed_s1 |=> out_valid_q && !ready_q && hold_q[0] == '0 &&
			hold_q[1] == '0 && hold_q[2] == '0 && hold_q[3] == '0)
		else $error("disarmed tick did not zero the outputs");

	// finishing spin-up clears the counter
	a_ready_clears_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ready_q) |-> counter_q == '0)
		else $error("counter not cleared when spin-up finished");

	// state only moves when a tick is processed
	a_state_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(counter_q) && $stable(ready_q))
		else $error("spin-up state changed without a tick");
`endif

endmodule

`default_nettype wire

// ----- bench/tb_quad_motor_spinup_mixer_top.sv -----
// Testbench for quad_motor_spinup_mixer_top: random and directed ticks, a
// per-tick predictor of spin-up and X-quad mixing, and APB register writes.
// Depends on qmsm_pkg, qmsm_tick_if / qmsm_cmd_if and the top module.
`default_nettype none

module tb_quad_motor_spinup_mixer_top;

	localparam int CycleLimit = 500000;
	localparam int MaxPrints  = 30;

	typedef struct packed {
		logic [qmsm_pkg::ElapsedW-1:0] elapsed_ms;
		logic                          armed;
		qmsm_pkg::ctl_t                throttle;
		qmsm_pkg::ctl_t                yaw_ctl;
		qmsm_pkg::ctl_t                roll_ctl;
		qmsm_pkg::ctl_t                pitch_ctl;
	} tick_t;

	typedef struct packed {
		qmsm_pkg::motor_t front_right;
		qmsm_pkg::motor_t front_left;
		qmsm_pkg::motor_t rear_left;
		qmsm_pkg::motor_t rear_right;
		logic             spun_up;
	} cmd_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [qmsm_pkg::AddrW-1:0] paddr;
	logic [qmsm_pkg::DataW-1:0] pwdata;
	logic [qmsm_pkg::DataW-1:0] prdata;
	logic pready;

	qmsm_tick_if tick_bus ();
	qmsm_cmd_if  cmd_bus ();

	quad_motor_spinup_mixer_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick_in (tick_bus),
		.cmd_out (cmd_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	// predictor state and its copy of the registers
	qmsm_pkg::motor_t            idle_q, max_q;
	logic [qmsm_pkg::StageW-1:0] stage_q;
	logic [qmsm_pkg::CntW-1:0]   spin_cnt;
	logic                        ready_q;
	qmsm_pkg::motor_t            hold_q [qmsm_pkg::NumMotors];

	tick_t ticks_pending [$];
	cmd_t  cmds_due [$];

	int errors = 0;
	int ticks_sent = 0;
	int results_seen = 0;
	int spinups_seen = 0;
	int cfg_writes = 0;
	int cycle_cnt = 0;
	logic last_spun = 1'b0;

	logic send_gaps_on, recv_gaps_on, hold_off;
	int   send_gap, recv_gap;

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (errors < MaxPrints)
			$display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want,
				results_seen);
		errors++;
	endtask

	function automatic qmsm_pkg::motor_t clamp_mix(int x);
		if (x < int'(idle_q))
			return idle_q;
		if (x > int'(max_q))
			return max_q;
		return qmsm_pkg::motor_t'(x);
	endfunction

	function automatic cmd_t spinup_mix_predict(tick_t t);
		cmd_t r;
		int c, s, thr, yaw, rol, pit;
		if (t.armed) begin
			if (!ready_q) begin
				spin_cnt = spin_cnt + t.elapsed_ms;
				c = spin_cnt;
				s = stage_q;
				if (c < s)
					hold_q[0] = idle_q;
				else if (c < 2 * s)
					hold_q[1] = idle_q;
				else if (c < 3 * s)
					hold_q[2] = idle_q;
				else if (c < 4 * s)
					hold_q[3] = idle_q;
				else begin
					ready_q = 1'b1;
					spin_cnt = '0;
				end
			end
			if (ready_q) begin
				thr = t.throttle;
				yaw = t.yaw_ctl;
				rol = t.roll_ctl;
				pit = t.pitch_ctl;
				hold_q[0] = clamp_mix(thr + yaw - rol + pit);
				hold_q[1] = clamp_mix(thr - yaw + rol + pit);
				hold_q[2] = clamp_mix(thr + yaw + rol - pit);
				hold_q[3] = clamp_mix(thr - yaw - rol - pit);
			end
		end else begin
			ready_q = 1'b0;
			foreach (hold_q[i])
				hold_q[i] = '0;
		end
		r.front_right = hold_q[0];
		r.front_left  = hold_q[1];
		r.rear_left   = hold_q[2];
		r.rear_right  = hold_q[3];
		r.spun_up     = ready_q;
		return r;
	endfunction

	function automatic qmsm_pkg::ctl_t rand_ctl(bit is_thr);
		case ($urandom_range(0, 3))
			0: return qmsm_pkg::ctl_t'($urandom_range(0, 4095));
			1: return $urandom_range(0, 1) ? qmsm_pkg::ctl_t'(2047) : qmsm_pkg::ctl_t'(-2048);
			default: begin
				if (is_thr)
					return qmsm_pkg::ctl_t'($urandom_range(0, 1100));
				return qmsm_pkg::ctl_t'(int'($urandom_range(0, 300)) - 150);
			end
		endcase
	endfunction

	// long_stage: keep elapsed high so a 16383 ms stage still completes
	function automatic tick_t rand_tick(bit long_stage);
		tick_t t;
		t.armed = ($urandom_range(0, 99) >= 4);
		if (long_stage)
			t.elapsed_ms = qmsm_pkg::ElapsedW'($urandom_range(180, 255));
		else if ($urandom_range(0, 9) == 0)
			t.elapsed_ms = $urandom_range(0, 1) ? '1 : '0;
		else
			t.elapsed_ms = qmsm_pkg::ElapsedW'($urandom_range(0, 255));
		t.throttle  = rand_ctl(1'b1);
		t.yaw_ctl   = rand_ctl(1'b0);
		t.roll_ctl  = rand_ctl(1'b0);
		t.pitch_ctl = rand_ctl(1'b0);
		return t;
	endfunction

	task automatic push_tick(int ms, bit arm, int thr, int yaw, int rol, int pit);
		tick_t t;
		t.elapsed_ms = qmsm_pkg::ElapsedW'(ms);
		t.armed      = arm;
		t.throttle   = qmsm_pkg::ctl_t'(thr);
		t.yaw_ctl    = qmsm_pkg::ctl_t'(yaw);
		t.roll_ctl   = qmsm_pkg::ctl_t'(rol);
		t.pitch_ctl  = qmsm_pkg::ctl_t'(pit);
		ticks_pending.push_back(t);
	endtask

	// checked on the falling edge, once the rising-edge updates have settled
	task automatic wait_drained();
		while (ticks_pending.size() != 0 || tick_bus.valid || cmds_due.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_idling();
		send_gaps_on <= ($urandom_range(0, 3) != 0);
		recv_gaps_on <= ($urandom_range(0, 3) != 0);
	endtask

	task automatic run_random(int n, bit long_stage);
		int k;
		set_idling();
		for (k = 0; k < n; k++)
			ticks_pending.push_back(rand_tick(long_stage));
		wait_drained();
	endtask

	// write, then read back; only called with the block drained
	task automatic program_reg(qmsm_pkg::reg_idx_t idx, logic [31:0] val);
		logic [31:0] want;
		want = (idx == qmsm_pkg::REG_STAGE) ? (val & 32'h3FFF) : (val & 32'h3FF);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want)
			report_mismatch("register readback", prdata, want);
		psel    <= 1'b0;
		penable <= 1'b0;
		cfg_writes++;
	endtask

	task automatic program_all(int idle, int mx, int st);
		program_reg(qmsm_pkg::REG_IDLE, idle);
		program_reg(qmsm_pkg::REG_MAX, mx);
		program_reg(qmsm_pkg::REG_STAGE, st);
	endtask

	// tick driver
	always @(posedge clk or negedge arst_n) begin : tick_driver
		tick_t nxt;
		if (!arst_n) begin
			tick_bus.valid <= 1'b0;
			send_gap <= 0;
		end else if (!(tick_bus.valid && !tick_bus.ready)) begin
			if (send_gap != 0) begin
				tick_bus.valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (ticks_pending.size() != 0) begin
				nxt = ticks_pending.pop_front();
				tick_bus.elapsed_ms <= nxt.elapsed_ms;
				tick_bus.armed      <= nxt.armed;
				tick_bus.throttle   <= nxt.throttle;
				tick_bus.yaw_ctl    <= nxt.yaw_ctl;
				tick_bus.roll_ctl   <= nxt.roll_ctl;
				tick_bus.pitch_ctl  <= nxt.pitch_ctl;
				tick_bus.valid      <= 1'b1;
				send_gap <= send_gaps_on ? $urandom_range(0, 8) : 0;
			end else begin
				tick_bus.valid <= 1'b0;
			end
		end
	end

	// result receiver; a zero gap keeps ready high for back-to-back transfers
	always @(posedge clk or negedge arst_n) begin : receiver
		int gap;
		if (!arst_n) begin
			cmd_bus.ready <= 1'b0;
			recv_gap <= 0;
		end else if (hold_off) begin
			cmd_bus.ready <= 1'b0;
		end else if (cmd_bus.valid && cmd_bus.ready) begin
			gap = recv_gaps_on ? int'($urandom_range(0, 8)) : 0;
			recv_gap <= gap;
			cmd_bus.ready <= (gap == 0);
		end else if (recv_gap != 0) begin
			cmd_bus.ready <= 1'b0;
			recv_gap <= recv_gap - 1;
		end else begin
			cmd_bus.ready <= 1'b1;
		end
	end

	// monitor: predict on tick transfer, check on result transfer
	always @(posedge clk) begin : monitor
		tick_t seen;
		cmd_t  want;
		if (arst_n) begin
			if (tick_bus.valid && tick_bus.ready) begin
				seen.elapsed_ms = tick_bus.elapsed_ms;
				seen.armed      = tick_bus.armed;
				seen.throttle   = tick_bus.throttle;
				seen.yaw_ctl    = tick_bus.yaw_ctl;
				seen.roll_ctl   = tick_bus.roll_ctl;
				seen.pitch_ctl  = tick_bus.pitch_ctl;
				cmds_due.push_back(spinup_mix_predict(seen));
				ticks_sent++;
			end
			if (cmd_bus.valid && cmd_bus.ready) begin
				if (cmds_due.size() == 0) begin
					report_mismatch("result with nothing expected", 0, 0);
				end else begin
					want = cmds_due.pop_front();
					if (cmd_bus.motor_front_right !== want.front_right)
						report_mismatch("motor_front_right", cmd_bus.motor_front_right,
							want.front_right);
					if (cmd_bus.motor_front_left !== want.front_left)
						report_mismatch("motor_front_left", cmd_bus.motor_front_left,
							want.front_left);
					if (cmd_bus.motor_rear_left !== want.rear_left)
						report_mismatch("motor_rear_left", cmd_bus.motor_rear_left,
							want.rear_left);
					if (cmd_bus.motor_rear_right !== want.rear_right)
						report_mismatch("motor_rear_right", cmd_bus.motor_rear_right,
							want.rear_right);
					if (cmd_bus.spun_up !== want.spun_up)
						report_mismatch("spun_up", cmd_bus.spun_up, want.spun_up);
					if (want.spun_up && !last_spun)
						spinups_seen++;
					last_spun = want.spun_up;
				end
				results_seen++;
			end
			if (psel && penable && pwrite && pready) begin
				case (qmsm_pkg::reg_idx_t'(paddr[3:2]))
					qmsm_pkg::REG_IDLE:  idle_q  = qmsm_pkg::motor_t'(pwdata);
					qmsm_pkg::REG_MAX:   max_q   = qmsm_pkg::motor_t'(pwdata);
					qmsm_pkg::REG_STAGE: stage_q = pwdata[qmsm_pkg::StageW-1:0];
					default: ;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CycleLimit) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt,
				cmds_due.size());
			$display("Some tests failed");
			$finish;
		end
	end

	// long receiver hold-off so the input side backs up
	initial begin : stall_bursts
		int k;
		hold_off = 1'b0;
		for (k = 0; k < 2; k++) begin
			while (results_seen < (k == 0 ? 150 : 1000))
				@(posedge clk);
			hold_off <= 1'b1;
			repeat (80) @(posedge clk);
			hold_off <= 1'b0;
		end
	end

	initial begin : stimulus
		int k;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tick_bus.valid = 1'b0;
		tick_bus.elapsed_ms = '0;
		tick_bus.armed = 1'b0;
		tick_bus.throttle = '0;
		tick_bus.yaw_ctl = '0;
		tick_bus.roll_ctl = '0;
		tick_bus.pitch_ctl = '0;
		cmd_bus.ready = 1'b0;
		send_gaps_on = 1'b1;
		recv_gaps_on = 1'b1;
		idle_q = qmsm_pkg::IdleReset;
		max_q = qmsm_pkg::MaxReset;
		stage_q = qmsm_pkg::StageReset;
		spin_cnt = '0;
		ready_q = 1'b0;
		foreach (hold_q[i])
			hold_q[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset register values
		push_tick(0, 0, 0, 0, 0, 0);
		push_tick(255, 0, 2047, 2047, 2047, 2047);
		push_tick(0, 1, 0, 0, 0, 0);
		push_tick(255, 1, 0, 0, 0, 0);
		push_tick(255, 1, 0, 0, 0, 0);
		push_tick(255, 1, 0, 0, 0, 0);
		// disarm mid spin-up: outputs drop, counter is kept
		push_tick(17, 0, 0, 0, 0, 0);
		// only the last motor starts; earlier ones hold zero
		push_tick(255, 1, 0, 0, 0, 0);
		push_tick(255, 1, 500, 10, 20, 30);
		push_tick(3, 1, 2047, 2047, 2047, 2047);
		push_tick(3, 1, -2048, -2048, -2048, -2048);
		push_tick(3, 1, 2047, -2048, -2048, 2047);
		push_tick(3, 1, -2048, 2047, 2047, -2048);
		push_tick(3, 1, 600, -50, 40, -30);
		push_tick(3, 1, 200, 0, 0, 0);
		push_tick(3, 1, 199, 0, 0, 0);
		push_tick(3, 1, 1000, 0, 0, 0);
		push_tick(3, 1, 1001, 0, 0, 0);
		push_tick(128, 0, -1, -1, -1, -1);
		push_tick(0, 1, 700, 0, 0, 0);
		push_tick(255, 1, 700, 100, -100, 50);
		wait_drained();
		run_random(250, 1'b0);

		program_all(0, 1023, 1);
		run_random(200, 1'b0);

		// zero stage length, idle above max
		program_all(1023, 0, 0);
		push_tick(255, 1, 0, 0, 0, 0);
		push_tick(0, 1, 2047, 0, 0, 0);
		run_random(180, 1'b0);
		push_tick(1, 1, 0, 0, 0, 0);
		push_tick(0, 0, 0, 0, 0, 0);
		wait_drained();

		// longest stage: step the counter past the last threshold so it wraps
		program_all(150, 900, 16383);
		set_idling();
		for (k = 0; k < 256; k++)
			push_tick(255, 1, rand_ctl(1'b1), rand_ctl(1'b0), rand_ctl(1'b0),
				rand_ctl(1'b0));
		push_tick(251, 1, 0, 0, 0, 0);
		push_tick(10, 1, 0, 0, 0, 0);
		wait_drained();
		run_random(250, 1'b1);

		program_all($urandom_range(0, 1023), $urandom_range(0, 1023),
			$urandom_range(1, 700));
		run_random(300, 1'b0);

		program_all(qmsm_pkg::IdleReset, qmsm_pkg::MaxReset, qmsm_pkg::StageReset);
		run_random(250, 1'b0);

		$display("Ran %0d ticks and checked %0d results over %0d register writes;",
			ticks_sent, results_seen, cfg_writes);
		$display("spin-up finished %0d times, including zero and wrapping stages.",
			spinups_seen);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire

// ----- sim.f -----
src/qmsm_pkg.sv
src/qmsm_if.sv
src/qmsm_regs.sv
src/qmsm_mixer.sv
src/quad_motor_spinup_mixer_top.sv
bench/tb_quad_motor_spinup_mixer_top.sv
